FILE: sv/satl_pkg.sv
// ----------------------------------------------------------------------------
// satl_pkg
// Shared widths, register indexes, policy codes and the controller-to-datapath
// command bundle of the set-associative tag lookup unit.
// ----------------------------------------------------------------------------
package satl_pkg;

  // fixed field widths
  localparam int ADDR_W      = 32;
  localparam int TAG_W       = 20;
  localparam int WAY_OUT_W   = 2;
  localparam int SET_OUT_W   = 6;
  localparam int LAT_W       = 8;
  localparam int CNT_W       = 32;
  localparam int POL_W       = 2;
  localparam int LFSR_W      = 16;

  // configuration port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LATENCY = 2'd1;

  // replacement policy codes (the fourth code picks way 0, no order update)
  localparam logic [POL_W-1:0] POL_LRU  = 2'd0;
  localparam logic [POL_W-1:0] POL_FIFO = 2'd1;
  localparam logic [POL_W-1:0] POL_RAND = 2'd2;

  // reset values
  localparam logic [POL_W-1:0]  POLICY_RST  = POL_LRU;
  localparam logic [LAT_W-1:0]  LATENCY_RST = 8'd1;
  localparam logic [LFSR_W-1:0] LFSR_SEED   = 16'hACE1;

  // default geometry
  localparam int DEF_NUM_SETS    = 64;
  localparam int DEF_WAYS        = 4;
  localparam int DEF_BLOCK_BYTES = 64;

  // commands from controller to datapath
  typedef struct packed {
    logic load;     // capture the address of an accepted access
    logic read;     // read the set row from the tag memory
    logic compare;  // compare tags, register hit and hit way
    logic update;   // pick way, write back row, update counters, drive result
  } satl_cmd_t;

endpackage

FILE: sv/satl_ctrl.sv
// ----------------------------------------------------------------------------
// satl_ctrl
// Sequencer of the lookup: idle, memory read, tag compare, update.
// ----------------------------------------------------------------------------
module satl_ctrl
  import satl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output satl_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_COMP = 4'b0100,
    ST_UPDT = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_COMP;
      ST_COMP: state_nxt = ST_UPDT;
      ST_UPDT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands and status
  assign busy        = (state_r != ST_IDLE);
  assign cmd.load    = (state_r == ST_IDLE) && start;
  assign cmd.read    = (state_r == ST_READ);
  assign cmd.compare = (state_r == ST_COMP);
  assign cmd.update  = (state_r == ST_UPDT);

endmodule

FILE: sv/satl_datapath.sv
// ----------------------------------------------------------------------------
// satl_datapath
// Tag/order memory, valid bits, tag compare, victim choice, order update,
// random pick, saturating counters, configuration and result registers.
// ----------------------------------------------------------------------------
module satl_datapath
  import satl_pkg::*;
#(
  parameter int NUM_SETS    = DEF_NUM_SETS,
  parameter int WAYS        = DEF_WAYS,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  satl_cmd_t             cmd,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [WAY_OUT_W-1:0]  out_way,
  output logic [SET_OUT_W-1:0]  out_set_number,
  output logic [TAG_W-1:0]      out_tag_value,
  output logic [LAT_W-1:0]      out_access_time,
  output logic [CNT_W-1:0]      out_hit_total,
  output logic [CNT_W-1:0]      out_miss_total
);

  localparam int OFF_W     = $clog2(BLOCK_BYTES);
  localparam int SET_BITS  = $clog2(NUM_SETS);
  localparam int SET_W     = (NUM_SETS > 1) ? SET_BITS : 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_SHIFT = OFF_W + SET_BITS;
  localparam int REC_OFS   = WAYS * TAG_W;
  localparam int ARR_OFS   = REC_OFS + WAYS * WAY_W;
  localparam int ROW_W     = ARR_OFS + WAYS * WAY_W;
  localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'(NUM_SETS - 1);
  // reciprocal for the random pick: q = (v * RAND_M) >> 24 is exact for 16-bit v
  localparam int RAND_SH = 24;
  localparam logic [RAND_SH:0] RAND_M = (RAND_SH + 1)'(((1 << RAND_SH) + WAYS - 1) / WAYS);
  localparam int PROD_W = LFSR_W + RAND_SH + 1;

  // configuration registers
  logic [POL_W-1:0] policy_r;
  logic [LAT_W-1:0] latency_r;

  // access registers
  logic [ADDR_W-1:0] addr_r;
  logic [ROW_W-1:0]  rd_row_r;
  logic              hit_r;
  logic [WAY_W-1:0]  hit_way_r;
  logic [LFSR_W-1:0] lfsr_r;
  logic [LFSR_W-1:0] rnd_q_r;
  logic [WAY_W-1:0]  rnd_way_r;
  logic [CNT_W-1:0]  hit_cnt_r;
  logic [CNT_W-1:0]  miss_cnt_r;
  logic [CNT_W-1:0]  hit_cnt_nxt;
  logic [CNT_W-1:0]  miss_cnt_nxt;

  // storage: one row per set holding tags, recency order and arrival order
  logic [ROW_W-1:0] row_mem [NUM_SETS];
  logic [WAYS-1:0]  valid_r [NUM_SETS];

  // decoded fields
  logic [SET_W-1:0]  set_idx;
  logic [TAG_W-1:0]  tag;
  logic [ADDR_W-1:0] tag_full;
  logic [WAYS-1:0]   vrow;
  logic              row_init;
  logic              hit_c;
  logic [WAY_W-1:0]  hit_way_c;
  logic [LFSR_W-1:0] lfsr_adv;
  logic [PROD_W-1:0] rnd_prod;
  logic [LFSR_W-1:0] rnd_rem;
  logic [WAY_W-1:0]  rec_q   [WAYS];
  logic [WAY_W-1:0]  arr_q   [WAYS];
  logic [WAY_W-1:0]  rec_new [WAYS];
  logic [WAY_W-1:0]  arr_new [WAYS];
  logic [WAY_W-1:0]  vict;
  logic [WAY_W-1:0]  sel_way;
  logic [WAY_W-1:0]  rec_pos;
  logic [WAY_W-1:0]  arr_pos;
  logic [ROW_W-1:0]  wr_row;

  // address split
  assign set_idx  = SET_W'((addr_r >> OFF_W) & SET_MASK);
  assign tag_full = addr_r >> TAG_SHIFT;
  assign tag      = tag_full[TAG_W-1:0];
  assign vrow     = valid_r[set_idx];
  assign row_init = |vrow;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= POLICY_RST;
      latency_r <= LATENCY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLICY:  policy_r  <= cfg_data[POL_W-1:0];
        REG_LATENCY: latency_r <= cfg_data[LAT_W-1:0];
        default:     ;
      endcase
    end
  end

  // address capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= in_address;
    end
  end

  // tag/order memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_row_r <= row_mem[set_idx];
    end
    if (cmd.update) begin
      row_mem[set_idx] <= wr_row;
    end
  end

  // tag compare, lowest matching way wins
  always_comb begin
    hit_c     = 1'b0;
    hit_way_c = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vrow[w] && (rd_row_r[w*TAG_W +: TAG_W] == tag)) begin
        hit_c     = 1'b1;
        hit_way_c = WAY_W'(w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      hit_r     <= hit_c;
      hit_way_r <= hit_way_c;
    end
  end

  // random pick: advance value, reciprocal multiply, then remainder
  assign lfsr_adv = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[LFSR_W-1:1]};
  assign rnd_prod = PROD_W'(lfsr_adv) * PROD_W'(RAND_M);
  assign rnd_rem  = lfsr_adv - LFSR_W'(rnd_q_r * LFSR_W'(WAYS));

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rnd_q_r <= rnd_prod[RAND_SH +: LFSR_W];
    end
    if (cmd.compare) begin
      rnd_way_r <= WAY_W'(rnd_rem);
    end
  end

  // orders of the set, way order until a first way of the set is valid
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      rec_q[i] = row_init ? rd_row_r[REC_OFS + i*WAY_W +: WAY_W] : WAY_W'(i);
      arr_q[i] = row_init ? rd_row_r[ARR_OFS + i*WAY_W +: WAY_W] : WAY_W'(i);
    end
  end

  // victim choice and selected way
  always_comb begin
    unique case (policy_r)
      POL_LRU:  vict = rec_q[WAYS-1];
      POL_FIFO: vict = arr_q[0];
      POL_RAND: vict = rnd_way_r;
      default:  vict = '0;
    endcase
    sel_way = hit_r ? hit_way_r : vict;
  end

  // position of the selected way in each order
  always_comb begin
    rec_pos = WAY_W'(WAYS - 1);
    arr_pos = WAY_W'(WAYS - 1);
    for (int p = WAYS - 1; p >= 0; p--) begin
      if (rec_q[p] == sel_way) rec_pos = WAY_W'(p);
      if (arr_q[p] == sel_way) arr_pos = WAY_W'(p);
    end
  end

  // recency: move to front under LRU; arrival: move to back on a FIFO fill
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      rec_new[i] = rec_q[i];
      arr_new[i] = arr_q[i];
    end
    if (policy_r == POL_LRU) begin
      for (int i = 1; i < WAYS; i++) begin
        if (WAY_W'(i) <= rec_pos) rec_new[i] = rec_q[i-1];
      end
      rec_new[0] = sel_way;
    end
    if ((policy_r == POL_FIFO) && !hit_r) begin
      for (int i = 0; i < WAYS - 1; i++) begin
        if (WAY_W'(i) >= arr_pos) arr_new[i] = arr_q[i+1];
      end
      arr_new[WAYS-1] = sel_way;
    end
  end

  // write-back row
  always_comb begin
    wr_row = rd_row_r;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_r && (sel_way == WAY_W'(w))) wr_row[w*TAG_W +: TAG_W] = tag;
      wr_row[REC_OFS + w*WAY_W +: WAY_W] = rec_new[w];
      wr_row[ARR_OFS + w*WAY_W +: WAY_W] = arr_new[w];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        valid_r[s] <= '0;
      end
    end else if (cmd.update && !hit_r) begin
      valid_r[set_idx][sel_way] <= 1'b1;
    end
  end

  // saturating counters
  assign hit_cnt_nxt  = (hit_r && (hit_cnt_r != '1)) ? hit_cnt_r + 1'b1 : hit_cnt_r;
  assign miss_cnt_nxt = (!hit_r && (miss_cnt_r != '1)) ? miss_cnt_r + 1'b1 : miss_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r     <= LFSR_SEED;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else if (cmd.update) begin
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
      if (!hit_r && (policy_r == POL_RAND)) lfsr_r <= lfsr_adv;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.update;
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit         <= hit_r;
      out_way         <= WAY_OUT_W'(sel_way);
      out_set_number  <= SET_OUT_W'((addr_r >> OFF_W) & SET_MASK);
      out_tag_value   <= tag;
      out_access_time <= hit_r ? latency_r : '0;
      out_hit_total   <= hit_cnt_nxt;
      out_miss_total  <= miss_cnt_nxt;
    end
  end

endmodule

FILE: sv/set_assoc_cache_tag_lookup_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_unit
// Tag and replacement engine of a set-associative cache: lookup, victim
// choice (LRU, FIFO, LFSR pick or way 0), tag install and hit/miss counters.
// ----------------------------------------------------------------------------
//
// channel  | handshake              | payload
// ---------+------------------------+------------------------------------------
// in       | start, busy            | in_address
// out      | out_valid (1 cycle)    | out_hit, out_way, out_set_number,
//          |                        | out_tag_value, out_access_time,
//          |                        | out_hit_total, out_miss_total
// cfg      | cfg_we                 | cfg_index, cfg_data
//
// busy is high after the transfer edge through the states of an access
// (tag memory read, tag compare, update and write-back) and the result strobe
// rises with busy falling, so a new access can start in that same cycle.
// reset clears valid bits, counters, lfsr and config at once; no clearing pass.
// the receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup_unit
  import satl_pkg::*;
#(
  parameter int NUM_SETS    = DEF_NUM_SETS,
  parameter int WAYS        = DEF_WAYS,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [WAY_OUT_W-1:0]  out_way,
  output logic [SET_OUT_W-1:0]  out_set_number,
  output logic [TAG_W-1:0]      out_tag_value,
  output logic [LAT_W-1:0]      out_access_time,
  output logic [CNT_W-1:0]      out_hit_total,
  output logic [CNT_W-1:0]      out_miss_total
);

  satl_cmd_t cmd;

  // sequencer
  satl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // lookup and replacement datapath
  satl_datapath #(
    .NUM_SETS    (NUM_SETS),
    .WAYS        (WAYS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_address      (in_address),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_way         (out_way),
    .out_set_number  (out_set_number),
    .out_tag_value   (out_tag_value),
    .out_access_time (out_access_time),
    .out_hit_total   (out_hit_total),
    .out_miss_total  (out_miss_total)
  );

  // an accepted access makes the unit busy on the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("access transfer did not raise busy");

  // every accepted access is followed by its result strobe
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("result strobe missing after access transfer");

  // a result is only shown once the sequencer is back in idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // a miss never reports a latency
  a_miss_time: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_access_time == '0))
    else $error("nonzero access time on a miss");

endmodule
